FILE: rtl/cnfr_pkg.sv
`default_nettype none

package cnfr_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_MESSAGE_BYTES = 32;
  localparam int DEF_ADDRESS_COPIES    = 3;

  // Widest frame the count field of a command must hold (parameter range tops at 64)
  localparam int MAX_MESSAGE_BYTES_TOP = 64;
  localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES_TOP + 1);

  localparam int BYTE_W    = 8;
  localparam int SIZE_W    = 6;
  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] BCAST_ADDR = 8'd255;
  localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h8C;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] RST_STATION_ID   = 8'd0;
  localparam logic [SIZE_W-1:0] RST_MESSAGE_SIZE = 6'd32;
  localparam logic [BYTE_W-1:0] RST_START_CODE   = 8'd2;
  localparam logic [BYTE_W-1:0] RST_END_CODE     = 8'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATION_ID   = 2'd0,
    CFG_MESSAGE_SIZE = 2'd1,
    CFG_START_CODE   = 2'd2,
    CFG_END_CODE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] station_id;
    logic [SIZE_W-1:0] message_size;
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
  } cfg_t;

  typedef enum logic {
    CMD_STORE   = 1'b0,
    CMD_DELIVER = 1'b1
  } cmd_kind_t;

  // store: count = write index, data = byte
  // deliver: count = frame length, data = received CRC, check = compare CRC
  typedef struct packed {
    cmd_kind_t         kind;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] data;
    logic              err;
    logic              check;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LOAD,
    BK_SEND
  } bk_state_t;

  // One byte of reflected CRC-8
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] d;
    logic              mix;
    c = crc_in;
    d = b;
    for (int k = 0; k < BYTE_W; k++) begin
      mix = c[0] ^ d[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cnfr_front.sv
`default_nettype none

module cnfr_front import cnfr_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES,
  parameter int ADDRESS_COPIES    = DEF_ADDRESS_COPIES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic              in_valid,
  input  wire logic              push_ready,
  output logic                   push,
  output cmd_t                   push_cmd
);

  localparam int CW       = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CCW      = $clog2(ADDRESS_COPIES + 1);
  localparam int AIW      = (ADDRESS_COPIES > 1) ? $clog2(ADDRESS_COPIES) : 1;
  localparam int VOTE_MIN = ADDRESS_COPIES / 2;
  localparam int CMPW     = (CW > SIZE_W) ? CW : SIZE_W;

  logic              in_frame, in_frame_next;
  logic              end_seen, end_seen_next;
  logic              error_seen, error_seen_next;
  logic              addressed, addressed_next;
  logic [CCW-1:0]    copy_count, copy_count_next;
  logic              high_half, high_half_next;
  logic [BYTE_W-1:0] assembled_byte, assembled_byte_next;
  logic [CW-1:0]     byte_count, byte_count_next;
  logic [BYTE_W-1:0] copies [ADDRESS_COPIES];
  logic              copy_we;

  // Hamming distances to start, end and the nearest nibble code
  logic [3:0] dist_start, dist_end, dist_nib;
  logic [3:0] d16 [16];
  logic [3:0] d8 [8];
  logic [3:0] d4 [4];
  logic [3:0] d2 [2];
  logic       is_start, is_end, legal;

  logic [ADDRESS_COPIES-1:0] mine_vec, bcast_vec;
  logic [CCW-1:0]            mine_cnt, bcast_cnt;
  logic                      vote;
  logic                      below_limit;
  logic                      accept;
  logic [BYTE_W-1:0]         copy_val;

  function automatic logic [3:0] pop8(input logic [BYTE_W-1:0] v);
    return 4'($countones(v));
  endfunction

  function automatic logic [3:0] min4(input logic [3:0] a, input logic [3:0] b);
    return (b < a) ? b : a;
  endfunction

  always_comb begin
    for (int h = 0; h < 16; h++) begin
      d16[h] = pop8(rx_byte ^ {4'(h), ~4'(h)});
    end
    for (int i = 0; i < 8; i++) begin
      d8[i] = min4(d16[2*i], d16[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      d4[i] = min4(d8[2*i], d8[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      d2[i] = min4(d4[2*i], d4[2*i+1]);
    end
    dist_nib   = min4(d2[0], d2[1]);
    dist_start = pop8(rx_byte ^ cfg.start_code);
    dist_end   = pop8(rx_byte ^ cfg.end_code);
  end

  // Start wins any tie; end wins ties with the nibble codes
  assign is_start = (dist_start <= dist_end) && (dist_start <= dist_nib);
  assign is_end   = (dist_end <= dist_nib) &&
                    ((dist_end < dist_start) || (cfg.start_code == cfg.end_code));
  assign legal    = (dist_start == 4'd0) || (dist_end == 4'd0) || (dist_nib == 4'd0);

  // Vote sees the incoming byte in place of the copy slot it is about to fill
  always_comb begin
    for (int i = 0; i < ADDRESS_COPIES; i++) begin
      copy_val     = (CCW'(i) == copy_count) ? rx_byte : copies[i];
      mine_vec[i]  = (copy_val == cfg.station_id);
      bcast_vec[i] = (copy_val == BCAST_ADDR);
    end
  end

  assign mine_cnt  = CCW'($countones(mine_vec));
  assign bcast_cnt = CCW'($countones(bcast_vec));
  assign vote      = (mine_cnt >= CCW'(VOTE_MIN)) || (bcast_cnt >= CCW'(VOTE_MIN));

  assign below_limit = (CMPW'(byte_count) < CMPW'(cfg.message_size)) &&
                       (CMPW'(byte_count) < CMPW'(MAX_MESSAGE_BYTES));

  assign accept = in_valid && push_ready;

  always_comb begin
    in_frame_next       = in_frame;
    end_seen_next       = end_seen;
    error_seen_next     = error_seen;
    addressed_next      = addressed;
    copy_count_next     = copy_count;
    high_half_next      = high_half;
    assembled_byte_next = assembled_byte;
    byte_count_next     = byte_count;
    copy_we             = 1'b0;
    push                = 1'b0;
    push_cmd            = '0;

    if (accept) begin
      if (!in_frame) begin
        if (is_start) begin
          in_frame_next   = 1'b1;
          end_seen_next   = 1'b0;
          byte_count_next = '0;
          high_half_next  = 1'b1;
        end else begin
          end_seen_next   = 1'b0;
          error_seen_next = 1'b0;
          addressed_next  = 1'b0;
          copy_count_next = '0;
          byte_count_next = '0;
        end
      end else if (copy_count < CCW'(ADDRESS_COPIES)) begin
        copy_we         = 1'b1;
        copy_count_next = copy_count + CCW'(1);
        if (copy_count == CCW'(ADDRESS_COPIES - 1)) begin
          addressed_next = vote;
        end
      end else if (is_end) begin
        end_seen_next = 1'b1;
      end else begin
        error_seen_next = error_seen || !legal;
        if (high_half) begin
          assembled_byte_next = {4'h0, rx_byte[7:4]};
          high_half_next      = 1'b0;
        end else begin
          assembled_byte_next = {assembled_byte[3:0], rx_byte[7:4]};
          high_half_next      = 1'b1;
        end

        if (end_seen && !high_half) begin
          // CRC byte complete: frame ends
          in_frame_next   = 1'b0;
          end_seen_next   = 1'b0;
          error_seen_next = 1'b0;
          addressed_next  = 1'b0;
          copy_count_next = '0;
          byte_count_next = '0;
          if (addressed) begin
            push           = 1'b1;
            push_cmd.kind  = CMD_DELIVER;
            push_cmd.count = CNT_W'(byte_count);
            push_cmd.data  = assembled_byte_next;
            push_cmd.err   = error_seen || !legal;
            push_cmd.check = 1'b1;
          end
        end else if (addressed && !high_half) begin
          push = 1'b1;
          if (below_limit) begin
            push_cmd.kind   = CMD_STORE;
            push_cmd.count  = CNT_W'(byte_count);
            push_cmd.data   = assembled_byte_next;
            byte_count_next = byte_count + CW'(1);
          end else begin
            // overflow: flush what is stored, flagged
            push_cmd.kind   = CMD_DELIVER;
            push_cmd.count  = CNT_W'(byte_count);
            push_cmd.err    = 1'b1;
            push_cmd.check  = 1'b0;
            in_frame_next   = 1'b0;
            end_seen_next   = 1'b0;
            error_seen_next = 1'b0;
            addressed_next  = 1'b0;
            copy_count_next = '0;
            byte_count_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      end_seen       <= 1'b0;
      error_seen     <= 1'b0;
      addressed      <= 1'b0;
      copy_count     <= '0;
      high_half      <= 1'b1;
      assembled_byte <= '0;
      byte_count     <= '0;
    end else begin
      in_frame       <= in_frame_next;
      end_seen       <= end_seen_next;
      error_seen     <= error_seen_next;
      addressed      <= addressed_next;
      copy_count     <= copy_count_next;
      high_half      <= high_half_next;
      assembled_byte <= assembled_byte_next;
      byte_count     <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (copy_we) begin
      copies[copy_count[AIW-1:0]] <= rx_byte;
    end
  end

  a_copy_count_range: assert property (@(posedge clk) disable iff (rst)
    copy_count <= CCW'(ADDRESS_COPIES))
    else $error("address copy count past the number of copies");

  a_store_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.kind == CMD_STORE) |-> (push_cmd.count < CNT_W'(MAX_MESSAGE_BYTES)))
    else $error("store index beyond message store");

endmodule

`default_nettype wire

FILE: rtl/cnfr_queue.sv
`default_nettype none

module cnfr_queue import cnfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      push_ready,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      pop_valid
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           entries [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push, do_pop;

  assign push_ready = (count != QCW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("command pushed into a full queue");

endmodule

`default_nettype wire

FILE: rtl/cnfr_back.sv
`default_nettype none

module cnfr_back import cnfr_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic              cmd_valid,
  output logic                   cmd_pop,
  output logic [BYTE_W-1:0]      data_byte,
  output logic                   data_valid,
  output logic                   frame_error,
  output logic [LEN_W-1:0]       frame_length,
  output logic                   last,
  output logic                   out_valid,
  input  wire logic              out_ready
);

  localparam int MW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;

  bk_state_t         state, state_next;
  logic [BYTE_W-1:0] mem [MAX_MESSAGE_BYTES];
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] crc;
  logic [BYTE_W-1:0] crc_eff;
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  idx;
  logic              err_r;
  logic              err_eff;
  logic              mem_we;
  logic              start_deliver;
  logic              load_out;
  logic              advance;

  // Empty frame checks against the CRC of nothing
  assign crc_eff = (cmd.count == '0) ? '0 : crc;
  assign err_eff = cmd.err || (cmd.check && (crc_eff != cmd.data));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_DELIVER) begin
          state_next = (cmd.count == '0) ? BK_SEND : BK_FETCH;
        end
      end
      BK_FETCH: state_next = BK_LOAD;
      BK_LOAD:  state_next = BK_SEND;
      BK_SEND: begin
        if (out_ready) begin
          state_next = last ? BK_IDLE : BK_FETCH;
        end
      end
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop       = (state == BK_IDLE) && cmd_valid;
    mem_we        = cmd_pop && (cmd.kind == CMD_STORE);
    start_deliver = cmd_pop && (cmd.kind == CMD_DELIVER);
    load_out      = (state == BK_LOAD);
    out_valid     = (state == BK_SEND);
    advance       = (state == BK_SEND) && out_ready && !last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      crc <= crc8_step((cmd.count == '0) ? '0 : crc, cmd.data);
    end
    if (start_deliver) begin
      len   <= cmd.count;
      err_r <= err_eff;
      idx   <= '0;
      if (cmd.count == '0) begin
        data_byte    <= '0;
        data_valid   <= 1'b0;
        frame_error  <= err_eff;
        frame_length <= '0;
        last         <= 1'b1;
      end
    end
    if (load_out) begin
      data_byte    <= rd_data;
      data_valid   <= 1'b1;
      frame_error  <= err_r;
      frame_length <= len[LEN_W-1:0];
      last         <= (idx + CNT_W'(1) == len);
    end
    if (advance) begin
      idx <= idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.count[MW-1:0]] <= cmd.data;
    end
    rd_data <= mem[idx[MW-1:0]];
  end

  a_empty_result_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !data_valid) |-> (last && data_byte == '0))
    else $error("empty-frame result malformed");

  a_load_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_LOAD) |-> (idx < len))
    else $error("read index past frame length");

  a_deliver_busy: assert property (@(posedge clk) disable iff (rst)
    start_deliver |=> (state != BK_IDLE))
    else $error("delivery command dropped");

endmodule

`default_nettype wire

FILE: rtl/complemented_nibble_frame_receiver.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// rx in    | in_valid / in_ready  | rx_byte
// result   | out_valid/ out_ready | data_byte, data_valid, frame_error,
//          |                      | frame_length, last
// config   | cfg_write            | cfg_index, cfg_data (no wait, no read-back)
//
// Front end takes one rx byte per cycle while the command queue (2 deep) has room.
// Back end: a stored data byte is written straight from idle; a delivered frame steps
//   each result through memory fetch, load and send, and keeps it busy until its last result.
// The front stalls (in_ready low) only while both queue slots are occupied.
// rst is synchronous, active high; it clears control state and restores config defaults.
// out_valid stalls keep the result register and back end held; the front runs on until the queue fills.
`default_nettype none

module complemented_nibble_frame_receiver import cnfr_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES,
  parameter int ADDRESS_COPIES    = DEF_ADDRESS_COPIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // receive bytes
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  // delivered message bytes
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [BYTE_W-1:0]          data_byte,
  output logic                       data_valid,
  output logic                       frame_error,
  output logic [LEN_W-1:0]           frame_length,
  output logic                       last
);

  cfg_t cfg;

  // Command path: front -> queue -> back
  logic push, push_ready;
  cmd_t push_cmd;
  logic pop, pop_valid;
  cmd_t pop_cmd;

  // Configuration registers; the user must write them only while the block is quiet, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_id   <= RST_STATION_ID;
      cfg.message_size <= RST_MESSAGE_SIZE;
      cfg.start_code   <= RST_START_CODE;
      cfg.end_code     <= RST_END_CODE;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_STATION_ID:   cfg.station_id   <= cfg_data;
        CFG_MESSAGE_SIZE: cfg.message_size <= cfg_data[SIZE_W-1:0];
        CFG_START_CODE:   cfg.start_code   <= cfg_data;
        CFG_END_CODE:     cfg.end_code     <= cfg_data;
        default:          cfg.station_id   <= cfg.station_id;
      endcase
    end
  end

  // A byte is accepted exactly when the queue can take whatever it produces
  assign in_ready = push_ready;

  // Front: code matching, address vote, nibble assembly, frame tracking
  cnfr_front #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
    .ADDRESS_COPIES    (ADDRESS_COPIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rx_byte    (rx_byte),
    .in_valid   (in_valid),
    .push_ready (push_ready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Decouples byte intake from frame delivery
  cnfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid)
  );

  // Back: message store, running CRC, result sequencing
  cnfr_back #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (pop_cmd),
    .cmd_valid    (pop_valid),
    .cmd_pop      (pop),
    .data_byte    (data_byte),
    .data_valid   (data_valid),
    .frame_error  (frame_error),
    .frame_length (frame_length),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

`default_nettype wire
